>>> rtl/core/descending_sorted_list_cursor_macros.svh
// Assertion macros shared by the sorted list cursor RTL.
`ifndef DESCENDING_SORTED_LIST_CURSOR_MACROS_SVH
`define DESCENDING_SORTED_LIST_CURSOR_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define DSLC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a trigger at one edge brings a condition at the next edge.
`define DSLC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/core/dslc_pkg.sv
// Shared types and constants of the sorted list cursor.
package dslc_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_FIRST = 3'd2,
    CMD_NEXT  = 3'd3,
    CMD_LAST  = 3'd4,
    CMD_PREV  = 3'd5
  } cmd_e;

  // Per-command decision from the cursor unit.
  typedef struct packed {
    logic insert;
    logic found;
    logic status;
  } upd_t;

endpackage

>>> rtl/core/dslc_cell.sv
// List slot: holds key and handle; an insert lands here or shifts it right.
module dslc_cell (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic                           occ_i,
  input  logic                           left_gt_i,
  input  logic [dslc_pkg::KEY_W-1:0]     new_key_i,
  input  logic [dslc_pkg::HANDLE_W-1:0]  new_handle_i,
  input  logic [dslc_pkg::KEY_W-1:0]     left_key_i,
  input  logic [dslc_pkg::HANDLE_W-1:0]  left_handle_i,
  output logic [dslc_pkg::KEY_W-1:0]     key_o,
  output logic [dslc_pkg::HANDLE_W-1:0]  handle_o,
  output logic                           gt_o
);

  logic [dslc_pkg::KEY_W-1:0]    key_q, key_d;
  logic [dslc_pkg::HANDLE_W-1:0] handle_q, handle_d;

  // Occupied slots with a strictly greater key form a prefix of the row.
  assign gt_o = occ_i && (key_q > new_key_i);

  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (load_i && !gt_o) begin
      if (left_gt_i) begin
        key_d    = new_key_i;
        handle_d = new_handle_i;
      end else begin
        key_d    = left_key_i;
        handle_d = left_handle_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

>>> rtl/core/dslc_cursor.sv
// Entry count and cursor register, with the command decode.
`include "descending_sorted_list_cursor_macros.svh"

module dslc_cursor #(
  parameter int unsigned DEPTH = dslc_pkg::DEPTH_DEF,
  localparam int unsigned PosW = $clog2(DEPTH),
  localparam int unsigned CntW = PosW + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [dslc_pkg::CMD_W-1:0]   command_i,
  input  logic [DEPTH-1:0]             gt_i,
  output logic [CntW-1:0]              cnt_o,
  output logic [PosW-1:0]              cur_o,
  output dslc_pkg::upd_t               upd_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] cur_q, cur_d;
  logic            cv_q, cv_d;
  logic [CntW-1:0] cur_ext, cur_nxt, cnt_m1;
  logic            full;

  assign cur_ext = {1'b0, cur_q};
  assign cur_nxt = cur_ext + CntW'(1);
  assign cnt_m1  = cnt_q - CntW'(1);
  assign full    = (cnt_q == CntW'(DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    cur_d = cur_q;
    cv_d  = cv_q;
    upd_o = '0;
    if (accept_i) begin
      case (dslc_pkg::cmd_e'(command_i))
        dslc_pkg::CMD_CLEAR: begin
          cnt_d = '0;
          cur_d = '0;
          cv_d  = 1'b0;
        end
        dslc_pkg::CMD_ADD: begin
          if (full) begin
            upd_o.status = 1'b1;
          end else begin
            upd_o.insert = 1'b1;
            cnt_d        = cnt_q + CntW'(1);
            if (cnt_q == '0) begin
              cur_d = '0;
              cv_d  = 1'b1;
            end else if (cv_q && !gt_i[cur_q]) begin
              // the cursor entry shifts one place toward the tail
              cur_d = cur_q + PosW'(1);
            end
          end
        end
        dslc_pkg::CMD_FIRST: begin
          if (cnt_q != '0) begin
            cur_d       = '0;
            cv_d        = 1'b1;
            upd_o.found = 1'b1;
          end
        end
        dslc_pkg::CMD_NEXT: begin
          if (cv_q) begin
            if (cur_nxt < cnt_q) begin
              cur_d       = cur_q + PosW'(1);
              upd_o.found = 1'b1;
            end else begin
              cv_d = 1'b0;
            end
          end
        end
        dslc_pkg::CMD_LAST: begin
          if (cnt_q != '0) begin
            cur_d       = cnt_m1[PosW-1:0];
            cv_d        = 1'b1;
            upd_o.found = 1'b1;
          end
        end
        dslc_pkg::CMD_PREV: begin
          if (cv_q) begin
            if (cur_q != '0 && cur_ext < cnt_q) begin
              cur_d       = cur_q - PosW'(1);
              upd_o.found = 1'b1;
            end else begin
              cv_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cur_q <= '0;
      cv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      cv_q  <= cv_d;
    end
  end

  assign cnt_o = cnt_q;
  assign cur_o = cur_q;

  `DSLC_ASSERT(a_cursor_in_list, !cv_q || (cur_ext < cnt_q), "cursor beyond last entry")
  `DSLC_ASSERT(a_count_bound, cnt_q <= CntW'(DEPTH), "entry count above depth")
  `DSLC_ASSERT_NEXT(a_clear_empties, accept_i && command_i == dslc_pkg::CMD_CLEAR, cnt_q == '0 && !cv_q, "clear left entries or cursor")

endmodule

>>> rtl/core/descending_sorted_list_cursor.sv
// Top level of the sorted list cursor: cell row, cursor unit and result register.
// Keeps up to DEPTH (handle, key) entries in descending key order in a row of
// cells; an add compares the new key in every cell at once and shifts the tail
// one cell right in the same cycle, so equal keys put the newest entry first.
// Each command runs as an update step for the cells and the cursor, then a
// read step that takes the handle under the cursor through a DEPTH-way select
// into the result register. One command is in work at a time, so the input
// stalls until the read step is done; a waiting result stalls the read step
// and so the input, but a command is accepted while a result sits unclaimed.
// No clearing pass follows reset: slots beyond the count are never read.
`include "descending_sorted_list_cursor_macros.svh"

module descending_sorted_list_cursor #(
  parameter int unsigned DEPTH = dslc_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dslc_pkg::CMD_W-1:0]     command_i,
  input  logic [dslc_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [dslc_pkg::KEY_W-1:0]     sort_key_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [dslc_pkg::HANDLE_W-1:0]  entry_handle_o,
  output logic [dslc_pkg::COUNT_W-1:0]   count_o,
  output logic                           status_o
);

  localparam int unsigned PosW = $clog2(DEPTH);
  localparam int unsigned CntW = PosW + 1;

  logic                          accept;
  logic [DEPTH-1:0]              gt;
  logic [CntW-1:0]               cnt;
  logic [PosW-1:0]               cur;
  dslc_pkg::upd_t                upd;
  logic [dslc_pkg::KEY_W-1:0]    key_row [DEPTH];
  logic [dslc_pkg::HANDLE_W-1:0] hdl_row [DEPTH];

  logic pend_q, found_q, status_q;
  logic out_valid_q, out_found_q, out_status_q;
  logic [dslc_pkg::HANDLE_W-1:0] out_handle_q;
  logic [dslc_pkg::COUNT_W-1:0]  out_count_q;
  logic [CntW+dslc_pkg::COUNT_W-1:0] cnt_ext;
  logic out_free, lookup;

  assign in_stall_o = pend_q;
  assign accept     = in_valid_i && !pend_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign lookup     = pend_q && out_free;
  assign cnt_ext    = {{dslc_pkg::COUNT_W{1'b0}}, cnt};

  dslc_cursor #(
    .DEPTH(DEPTH)
  ) u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .command_i(command_i),
    .gt_i     (gt),
    .cnt_o    (cnt),
    .cur_o    (cur),
    .upd_o    (upd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          left_gt;
    logic [dslc_pkg::KEY_W-1:0]    left_key;
    logic [dslc_pkg::HANDLE_W-1:0] left_hdl;

    if (i == 0) begin : g_head
      // head slot takes the new entry unless it holds a greater key
      assign left_gt  = 1'b1;
      assign left_key = sort_key_i;
      assign left_hdl = handle_i;
    end else begin : g_body
      assign left_gt  = gt[i-1];
      assign left_key = key_row[i-1];
      assign left_hdl = hdl_row[i-1];
    end

    dslc_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (upd.insert),
      .occ_i        (CntW'(i) < cnt),
      .left_gt_i    (left_gt),
      .new_key_i    (sort_key_i),
      .new_handle_i (handle_i),
      .left_key_i   (left_key),
      .left_handle_i(left_hdl),
      .key_o        (key_row[i]),
      .handle_o     (hdl_row[i]),
      .gt_o         (gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (lookup) begin
        pend_q <= 1'b0;
      end
      if (lookup) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q  <= upd.found;
      status_q <= upd.status;
    end
    // read the entry under the cursor once the cell row has settled
    if (lookup) begin
      out_found_q  <= found_q;
      out_status_q <= status_q;
      out_handle_q <= found_q ? hdl_row[cur] : '0;
      out_count_q  <= cnt_ext[dslc_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign entry_handle_o = out_handle_q;
  assign count_o        = out_count_q;
  assign status_o       = out_status_q;

  `DSLC_ASSERT_NEXT(a_accept_pends, accept, pend_q, "accepted command not held for lookup")
  `DSLC_ASSERT_NEXT(a_lookup_emits, lookup, out_valid_q && !pend_q, "lookup did not load result")
  `DSLC_ASSERT(a_null_handle, !out_valid_q || out_found_q || out_handle_q == '0, "handle set without entry")

endmodule
